### design/tcon_pkg.sv
`default_nettype none

package tcon_pkg;

    // Fixed field and state widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 12;
    localparam int OFS_W  = 11;

    // Command codes on the input port
    localparam logic [2:0] CMD_PUT   = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_ROLL  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Character and attribute constants
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] BLANK_CHAR   = 8'h00;
    localparam logic [7:0] BLANK_ATTR   = 8'h07;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_SET,
        OP_CLEAR,
        OP_ROLL,
        OP_READ,
        OP_NOP
    } t_op;

    // addr: row base for set, cell index for read, shift in cells for roll
    typedef struct packed {
        t_op               op;
        logic [7:0]        char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    // Request to the character and attribute stores
    typedef struct packed {
        logic              we_char;
        logic              we_attr;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wchar;
        logic [7:0]        wattr;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

### design/tcon_ram.sv
`default_nettype none

module tcon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/tcon_front.sv
`default_nettype none

module tcon_front
    import tcon_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_hold,
    output      logic       o_full,
    input  wire logic [2:0] i_command,
    input  wire logic [7:0] i_char_code,
    input  wire logic [7:0] i_column,
    input  wire logic [7:0] i_row,
    input  wire logic [7:0] i_roll_lines,
    output      logic       o_cmd_valid,
    output      t_cmd       o_cmd,
    input  wire logic       i_cmd_take
);

    localparam int QDEPTH = 2;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] roll_shift;
    t_cmd              cmd;
    logic              push_ok;

    t_cmd              r_q [QDEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    // Clamp coordinates and form cell addresses
    assign col_c = (i_column >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1) : i_column[COL_W-1:0];
    assign row_c = (i_row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : i_row[ROW_W-1:0];
    assign row_base   = {{(ADDR_W-ROW_W){1'b0}}, row_c} * COLS_A;
    assign roll_shift = {{(ADDR_W-ROW_W){1'b0}}, i_roll_lines[ROW_W-1:0]} * COLS_A;

    // Classify the incoming transaction
    always_comb begin
        cmd           = '0;
        cmd.op        = OP_NOP;
        cmd.char_code = i_char_code;
        cmd.col       = col_c;
        cmd.row       = row_c;
        case (i_command)
            CMD_PUT: begin
                cmd.op = (i_char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            end
            CMD_SET: begin
                cmd.op   = OP_SET;
                cmd.addr = row_base;
            end
            CMD_CLEAR: begin
                cmd.op = OP_CLEAR;
            end
            CMD_ROLL: begin
                if (i_roll_lines == 8'd0) begin
                    cmd.op = OP_NOP;
                end else if (i_roll_lines >= 8'(ROWS)) begin
                    cmd.op = OP_CLEAR;
                end else begin
                    cmd.op   = OP_ROLL;
                    cmd.addr = roll_shift;
                end
            end
            CMD_READ: begin
                cmd.op   = OP_READ;
                cmd.addr = row_base + {{(ADDR_W-COL_W){1'b0}}, col_c};
            end
            default: begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    // Two-entry command queue toward the back end
    assign o_full      = (r_cnt == 2'(QDEPTH)) || i_hold;
    assign push_ok     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(i_cmd_take);
        end
    end

endmodule

`default_nettype wire

### design/tcon_back.sv
`default_nettype none

module tcon_back
    import tcon_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output      logic             o_cmd_take,
    output      logic             o_busy,
    output      t_mem_req         o_mem,
    input  wire logic [7:0]       i_rd_char,
    input  wire logic [7:0]       i_rd_attr,
    output      logic             o_empty,
    input  wire logic             i_pop,
    output      logic [OFS_W-1:0] o_cursor_offset,
    output      logic [7:0]       o_cell_char,
    output      logic [7:0]       o_cell_attr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ROLL,
        S_READ
    } t_state;

    t_state            r_state,   n_state;
    logic [ADDR_W-1:0] r_ptr,     n_ptr;
    logic [ADDR_W-1:0] r_shift,   n_shift;
    logic [COL_W-1:0]  r_col,     n_col;
    logic [ROW_W-1:0]  r_row,     n_row;
    logic [ADDR_W-1:0] r_base,    n_base;
    logic              r_out_valid, n_out_valid;
    logic [OFS_W-1:0]  r_out_off,   n_out_off;
    logic [7:0]        r_out_char,  n_out_char;
    logic [7:0]        r_out_attr,  n_out_attr;

    logic              out_free;
    logic              emit;
    logic              next_line;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] keep;
    logic [ADDR_W:0]   next_src;
    logic [ADDR_W-1:0] sum_ofs;

    assign out_free = !r_out_valid || i_pop;
    assign cur_addr = r_base + {{(ADDR_W-COL_W){1'b0}}, r_col};
    assign keep     = ADDR_W'(CELLS) - r_shift;
    assign next_src = {1'b0, r_ptr} + {1'b0, r_shift} + (ADDR_W+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_shift     = r_shift;
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_out_valid = r_out_valid && !i_pop;
        n_out_off   = r_out_off;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        o_cmd_take  = 1'b0;
        o_mem       = '0;
        emit        = 1'b0;
        next_line   = 1'b0;
        sum_ofs     = '0;

        case (r_state)
            // Blank sweep over every cell, after reset or on clear
            S_INIT, S_CLEAR: begin
                o_mem.we_char = 1'b1;
                o_mem.we_attr = 1'b1;
                o_mem.waddr   = r_ptr;
                o_mem.wchar   = BLANK_CHAR;
                o_mem.wattr   = BLANK_ATTR;
                if (r_ptr == LAST_A) begin
                    n_state = S_IDLE;
                    emit    = (r_state == S_CLEAR);
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end

            // Copy rows up, read running one cell ahead, blank the tail
            S_ROLL: begin
                o_mem.we_char = 1'b1;
                o_mem.we_attr = 1'b1;
                o_mem.waddr   = r_ptr;
                if (r_ptr < keep) begin
                    o_mem.wchar = i_rd_char;
                    o_mem.wattr = i_rd_attr;
                end else begin
                    o_mem.wchar = BLANK_CHAR;
                    o_mem.wattr = BLANK_ATTR;
                end
                o_mem.raddr = (next_src < (ADDR_W+1)'(CELLS)) ? next_src[ADDR_W-1:0] : '0;
                if (r_ptr == LAST_A) begin
                    n_state = S_IDLE;
                    emit    = 1'b1;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end

            S_READ: begin
                n_state = S_IDLE;
                emit    = 1'b1;
            end

            // Take one command when the result slot is free
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    case (i_cmd.op)
                        OP_PUT: begin
                            o_mem.we_char = 1'b1;
                            o_mem.waddr   = cur_addr;
                            o_mem.wchar   = i_cmd.char_code;
                            if (r_col == COL_W'(COLUMNS - 1)) begin
                                next_line = 1'b1;
                            end else begin
                                n_col = r_col + COL_W'(1);
                                emit  = 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            next_line = 1'b1;
                        end
                        OP_SET: begin
                            n_col  = i_cmd.col;
                            n_row  = i_cmd.row;
                            n_base = i_cmd.addr;
                            emit   = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_base  = '0;
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_ROLL: begin
                            n_shift     = i_cmd.addr;
                            n_ptr       = '0;
                            o_mem.raddr = i_cmd.addr;
                            n_state     = S_ROLL;
                        end
                        OP_READ: begin
                            o_mem.raddr = i_cmd.addr;
                            n_state     = S_READ;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase

                    // Cursor to the next row; on the last row roll up one line
                    if (next_line) begin
                        n_col = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            n_shift     = COLS_A;
                            n_ptr       = '0;
                            o_mem.raddr = COLS_A;
                            n_state     = S_ROLL;
                        end else begin
                            n_row  = r_row + ROW_W'(1);
                            n_base = r_base + COLS_A;
                            emit   = 1'b1;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register
        if (emit) begin
            sum_ofs     = n_base + {{(ADDR_W-COL_W){1'b0}}, n_col};
            n_out_valid = 1'b1;
            n_out_off   = sum_ofs[OFS_W-1:0];
            n_out_char  = (r_state == S_READ) ? i_rd_char : 8'h00;
            n_out_attr  = (r_state == S_READ) ? i_rd_attr : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_shift     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_shift     <= n_shift;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
        r_out_off  <= n_out_off;
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
    end

    assign o_busy          = (r_state == S_INIT);
    assign o_empty         = !r_out_valid;
    assign o_cursor_offset = r_out_off;
    assign o_cell_char     = r_out_char;
    assign o_cell_attr     = r_out_attr;

endmodule

`default_nettype wire

### design/text_console_engine_top.sv
// Text-mode console engine: character and attribute stores of COLUMNS x ROWS
// cells plus a cursor.
// Input channel: a command transaction is taken on a rising edge with i_push
// high and o_full low. Commands are put char, set cursor, clear, roll up and
// read cell. Result channel: the oldest result sits on o_cursor_offset,
// o_cell_char and o_cell_attr while o_empty is low; it is taken on an edge
// with i_pop high. Every command gives exactly one result.
// A two-entry command queue sits between the decode front end and the store
// sequencer, so pushes continue while a result waits to be popped.
// Put char, newline, set cursor, roll up by zero and unknown commands need
// no store read, read cell waits for a registered store read, and clear,
// any other roll up, and a put char or newline that leaves the last row
// sweep the store one cell per cycle.
// Sustained rate: one simple command per cycle while results are popped.
// Reset: a blanking pass writes char 0x00 and attribute 0x07 to every cell;
// o_full stays high until it is done.
// When the receiver stalls, one result is held, the sequencer waits, and the
// queue fills until o_full rises.
`default_nettype none

module text_console_engine_top
    import tcon_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output      logic              o_full,
    input  wire logic [2:0]        i_command,
    input  wire logic [7:0]        i_char_code,
    input  wire logic [7:0]        i_column,
    input  wire logic [7:0]        i_row,
    input  wire logic [7:0]        i_roll_lines,
    output      logic              o_empty,
    input  wire logic              i_pop,
    output      logic [OFS_W-1:0]  o_cursor_offset,
    output      logic [7:0]        o_cell_char,
    output      logic [7:0]        o_cell_attr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic     cmd_valid;
    t_cmd     cmd;
    logic     cmd_take;
    logic     busy;
    t_mem_req mem;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;

    // Decode front end with command queue
    tcon_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_hold       (busy),
        .o_full       (o_full),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_roll_lines (i_roll_lines),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    // Store sequencer and result register
    tcon_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_take      (cmd_take),
        .o_busy          (busy),
        .o_mem           (mem),
        .i_rd_char       (rd_char),
        .i_rd_attr       (rd_attr),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_cursor_offset (o_cursor_offset),
        .o_cell_char     (o_cell_char),
        .o_cell_attr     (o_cell_attr)
    );

    // Character store
    tcon_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_char),
        .i_waddr (mem.waddr[AW-1:0]),
        .i_wdata (mem.wchar),
        .i_raddr (mem.raddr[AW-1:0]),
        .o_rdata (rd_char)
    );

    // Attribute store
    tcon_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_attr),
        .i_waddr (mem.waddr[AW-1:0]),
        .i_wdata (mem.wattr),
        .i_raddr (mem.raddr[AW-1:0]),
        .o_rdata (rd_attr)
    );

endmodule

`default_nettype wire
